// ===== hdl/tga_rle_pixel_decoder_assert.svh =====
// Assertion macros for the TGA run-length pixel decoder.
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every rising edge outside reset.
`define TRD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define TRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define TRD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/trd_pkg.sv =====
// Types and constants of the TGA run-length pixel decoder.
package trd_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] pix_cnt_t;
    typedef logic [1:0]  fmt_t;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // register indexes
    localparam cfg_index_t REG_PIXEL_FORMAT = 1'd0;
    localparam cfg_index_t REG_PIXEL_TOTAL  = 1'd1;

    // pixel format codes
    localparam fmt_t FMT_GRAY = 2'd0;
    localparam fmt_t FMT_BGR  = 2'd1;
    localparam fmt_t FMT_BGRA = 2'd2;

    // packet header fields
    localparam int          RUN_FLAG_BIT = 7;
    localparam logic [6:0]  COUNT_MASK   = 7'h7f;

    // reset values of the registers
    localparam fmt_t     FORMAT_RESET = FMT_BGR;
    localparam pix_cnt_t TOTAL_RESET  = 32'd1;

    // zero total is taken as a one-pixel image
    function automatic pix_cnt_t image_size(input pix_cnt_t total);
        image_size = (total == '0) ? pix_cnt_t'(1) : total;
    endfunction

    // byte position of the last byte of a pixel
    function automatic logic [1:0] last_pos(input fmt_t fmt);
        case (fmt)
            FMT_GRAY: last_pos = 2'd0;
            FMT_BGR:  last_pos = 2'd2;
            default:  last_pos = 2'd3;
        endcase
    endfunction

endpackage

// ===== hdl/tga_rle_pixel_decoder.sv =====
// Top level of the TGA run-length pixel decoder.
//
// Usage:
//   s_ channel: one byte of the compressed TGA pixel stream per beat.
//   m_ channel: one decoded pixel per beat (red, green, blue, alpha, with
//     a repeat count 1..128, an image end flag and an overrun flag).
//   cfg port: write-only; index 0 pixel format (0 gray, 1 BGR, 2 BGRA),
//     index 1 pixels per image. Any write restarts decoding at a header.
//   Throughput: one input byte per cycle while the output is not stalled.
//     All decode work sits between the input handshake and the output
//     register, so the figure is set by that single register stage.
//   Latency: the pixel appears on m_ the cycle after its last byte beat.
//   Header bytes and leading pixel bytes produce no output beat.
//   Stall: while m_valid is high and m_ready low, s_ready drops; nothing
//     is lost and the held output beat stays put. s_ready is high again
//     in the cycle that the output beat is taken.
//   Reset (aresetn low, synchronous): format BGR, one pixel per image,
//     next byte is a header, no output pending.
//   After the beat that completes an image the decoder restarts by itself.
//   A packet longer than the pixels left is clamped and its beats flagged.
module tga_rle_pixel_decoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    // byte stream in
    input  logic                         s_valid,
    output logic                         s_ready,
    input  trd_pkg::byte_t               s_data_byte,
    // pixels out
    output logic                         m_valid,
    input  logic                         m_ready,
    output trd_pkg::byte_t               m_red,
    output trd_pkg::byte_t               m_green,
    output trd_pkg::byte_t               m_blue,
    output trd_pkg::byte_t               m_alpha,
    output trd_pkg::byte_t               m_repeat_count,
    output logic                         m_image_end,
    output logic                         m_overrun,
    // register writes
    input  logic                         cfg_wr_en,
    input  trd_pkg::cfg_index_t          cfg_index,
    input  logic [trd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import trd_pkg::*;

    `include "tga_rle_pixel_decoder_assert.svh"

    // configuration
    fmt_t     pixel_format_reg, pixel_format_next;
    pix_cnt_t pixel_total_reg,  pixel_total_next;

    // decode state
    pix_cnt_t    pixels_remaining_reg, pixels_remaining_next;
    byte_t       packet_left_reg,      packet_left_next;
    logic        packet_is_run_reg,    packet_is_run_next;
    logic        packet_clamped_reg,   packet_clamped_next;
    logic [1:0]  byte_pos_reg,         byte_pos_next;
    byte_t       pix_b0_reg, pix_b0_next;
    byte_t       pix_b1_reg, pix_b1_next;
    byte_t       pix_b2_reg, pix_b2_next;

    // output register
    logic        m_valid_reg,   m_valid_next;
    byte_t       red_reg,       red_next;
    byte_t       green_reg,     green_next;
    byte_t       blue_reg,      blue_next;
    byte_t       alpha_reg,     alpha_next;
    byte_t       rep_reg,       rep_next;
    logic        end_reg,       end_next;
    logic        overrun_reg,   overrun_next;

    logic        in_beat;
    logic        is_header;
    logic        pixel_done;
    byte_t       hdr_cnt;
    byte_t       rep_val;
    pix_cnt_t    remain_after;
    logic        image_done;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_beat = s_valid && s_ready;

    assign is_header  = (packet_left_reg == '0);
    assign pixel_done = !is_header && (byte_pos_reg == last_pos(pixel_format_reg));
    assign hdr_cnt    = byte_t'({1'b0, s_data_byte[6:0] & COUNT_MASK}) + byte_t'(1);
    assign rep_val    = packet_is_run_reg ? packet_left_reg : byte_t'(1);
    assign remain_after = pixels_remaining_reg - pix_cnt_t'(rep_val);
    assign image_done = (remain_after == '0);

    always_comb begin
        pixel_format_next     = pixel_format_reg;
        pixel_total_next      = pixel_total_reg;
        pixels_remaining_next = pixels_remaining_reg;
        packet_left_next      = packet_left_reg;
        packet_is_run_next    = packet_is_run_reg;
        packet_clamped_next   = packet_clamped_reg;
        byte_pos_next         = byte_pos_reg;
        pix_b0_next           = pix_b0_reg;
        pix_b1_next           = pix_b1_reg;
        pix_b2_next           = pix_b2_reg;

        m_valid_next = m_valid_reg && !m_ready;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        alpha_next   = alpha_reg;
        rep_next     = rep_reg;
        end_next     = end_reg;
        overrun_next = overrun_reg;

        if (cfg_wr_en) begin
            // the user is to write only while idle; the block does not enforce it; each write restarts the decoder
            unique case (cfg_index)
                REG_PIXEL_FORMAT: begin
                    pixel_format_next     = cfg_data[1:0];
                    pixels_remaining_next = image_size(pixel_total_reg);
                end
                REG_PIXEL_TOTAL: begin
                    pixel_total_next      = cfg_data[31:0];
                    pixels_remaining_next = image_size(cfg_data[31:0]);
                end
                default: ;
            endcase
            packet_left_next    = '0;
            packet_is_run_next  = 1'b0;
            packet_clamped_next = 1'b0;
            byte_pos_next       = '0;
        end else if (in_beat) begin
            if (is_header) begin
                packet_is_run_next = s_data_byte[RUN_FLAG_BIT];
                byte_pos_next      = '0;
                if (pix_cnt_t'(hdr_cnt) > pixels_remaining_reg) begin
                    // remaining is below 128 here, so it fits
                    packet_left_next    = pixels_remaining_reg[7:0];
                    packet_clamped_next = 1'b1;
                end else begin
                    packet_left_next    = hdr_cnt;
                    packet_clamped_next = 1'b0;
                end
            end else if (!pixel_done) begin
                case (byte_pos_reg)
                    2'd0:    pix_b0_next = s_data_byte;
                    2'd1:    pix_b1_next = s_data_byte;
                    default: pix_b2_next = s_data_byte;
                endcase
                byte_pos_next = byte_pos_reg + 2'd1;
            end else begin
                // last byte of a pixel: emit it
                m_valid_next = 1'b1;
                case (pixel_format_reg)
                    FMT_GRAY: begin
                        red_next   = s_data_byte;
                        green_next = '0;
                        blue_next  = '0;
                        alpha_next = '0;
                    end
                    FMT_BGR: begin
                        red_next   = s_data_byte;
                        green_next = pix_b1_reg;
                        blue_next  = pix_b0_reg;
                        alpha_next = '0;
                    end
                    default: begin
                        red_next   = pix_b2_reg;
                        green_next = pix_b1_reg;
                        blue_next  = pix_b0_reg;
                        alpha_next = s_data_byte;
                    end
                endcase
                rep_next      = rep_val;
                end_next      = image_done;
                overrun_next  = packet_clamped_reg;
                byte_pos_next = '0;

                if (image_done) begin
                    pixels_remaining_next = image_size(pixel_total_reg);
                    packet_left_next      = '0;
                    packet_is_run_next    = 1'b0;
                    packet_clamped_next   = 1'b0;
                end else begin
                    pixels_remaining_next = remain_after;
                    packet_left_next      = packet_is_run_reg ? byte_t'(0)
                                                              : packet_left_reg - byte_t'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg     <= FORMAT_RESET;
            pixel_total_reg      <= TOTAL_RESET;
            pixels_remaining_reg <= image_size(TOTAL_RESET);
            packet_left_reg      <= '0;
            packet_is_run_reg    <= 1'b0;
            packet_clamped_reg   <= 1'b0;
            byte_pos_reg         <= '0;
            m_valid_reg          <= 1'b0;
        end else begin
            pixel_format_reg     <= pixel_format_next;
            pixel_total_reg      <= pixel_total_next;
            pixels_remaining_reg <= pixels_remaining_next;
            packet_left_reg      <= packet_left_next;
            packet_is_run_reg    <= packet_is_run_next;
            packet_clamped_reg   <= packet_clamped_next;
            byte_pos_reg         <= byte_pos_next;
            m_valid_reg          <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        pix_b0_reg  <= pix_b0_next;
        pix_b1_reg  <= pix_b1_next;
        pix_b2_reg  <= pix_b2_next;
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
        alpha_reg   <= alpha_next;
        rep_reg     <= rep_next;
        end_reg     <= end_next;
        overrun_reg <= overrun_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_alpha        = alpha_reg;
    assign m_repeat_count = rep_reg;
    assign m_image_end    = end_reg;
    assign m_overrun      = overrun_reg;

    // pixel count never reaches zero while decoding
    `TRD_ASSERT(a_remain_nonzero, aclk, aresetn, pixels_remaining_reg != '0, "pixels remaining is zero")

    // a packet never owes more than the image
    `TRD_ASSERT(a_packet_fits, aclk, aresetn, pix_cnt_t'(packet_left_reg) <= pixels_remaining_reg, "packet exceeds image")

    // emitted repeat count is 1..128
    `TRD_ASSERT(a_rep_range, aclk, aresetn, m_valid_reg |-> (rep_reg != '0 && rep_reg <= 8'd128), "repeat count out of range")

    // completing an image restarts the decoder
    `TRD_ASSERT(a_image_restart, aclk, aresetn, (in_beat && pixel_done && image_done && !cfg_wr_en) |=> (packet_left_reg == '0 && pixels_remaining_reg == image_size(pixel_total_reg) && m_valid_reg && end_reg), "no restart after image end")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the TGA run-length pixel decoder.
`timescale 1ns / 1ps

module tb_top;
    import trd_pkg::*;

    localparam int QUIET_LIMIT = 2000;  // cycles without any beat before giving up
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int RANDOM_BYTES = 600;
    localparam pix_cnt_t TOTAL_MAX = 32'hfffe_0001;

    // one decoded pixel as seen on the m_ channel
    typedef struct {
        byte_t red;
        byte_t green;
        byte_t blue;
        byte_t alpha;
        byte_t repeat_count;
        logic  image_end;
        logic  overrun;
    } pixel_t;

    // Tracks decoder state from the accepted byte stream and checks pixels in order.
    class rle_pixel_tracker;
        fmt_t     format;
        pix_cnt_t total;
        pix_cnt_t image_left;
        byte_t    packet_left;
        bit       run_packet;
        bit       clamped;
        int       byte_pos;
        byte_t    held[3];
        pixel_t   owed[$];
        int       faults;

        function void restart();
            image_left  = (total == '0) ? pix_cnt_t'(1) : total;
            packet_left = '0;
            run_packet  = 1'b0;
            clamped     = 1'b0;
            byte_pos    = 0;
        endfunction

        function void power_up();
            format = FORMAT_RESET;
            total  = TOTAL_RESET;
            owed.delete();
            restart();
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PIXEL_FORMAT: format = value[1:0];
                REG_PIXEL_TOTAL:  total = value;
                default: return;
            endcase
            restart();
        endfunction

        // one accepted input beat
        function void note_byte(byte_t b);
            pix_cnt_t count;
            int       last;
            pixel_t   px;

            if (packet_left == '0) begin
                // header: count is low 7 bits + 1, clamp to what the image still owes
                count      = pix_cnt_t'(b[6:0]) + 1;
                run_packet = b[RUN_FLAG_BIT];
                clamped    = 1'b0;
                if (count > image_left) begin
                    count   = image_left;
                    clamped = 1'b1;
                end
                packet_left = byte_t'(count);
                byte_pos    = 0;
                return;
            end

            case (format)
                FMT_GRAY: last = 0;
                FMT_BGR:  last = 2;
                default:  last = 3;  // BGRA, and code three
            endcase
            if (byte_pos < last) begin
                held[byte_pos] = b;
                byte_pos++;
                return;
            end

            px.red   = '0;
            px.green = '0;
            px.blue  = '0;
            px.alpha = '0;
            case (format)
                FMT_GRAY: px.red = b;
                FMT_BGR: begin
                    px.blue  = held[0];
                    px.green = held[1];
                    px.red   = b;
                end
                default: begin
                    px.blue  = held[0];
                    px.green = held[1];
                    px.red   = held[2];
                    px.alpha = b;
                end
            endcase
            byte_pos = 0;

            if (run_packet) begin
                px.repeat_count = packet_left;
                packet_left     = '0;
            end else begin
                px.repeat_count = 8'd1;
                packet_left--;
            end
            image_left   = image_left - pix_cnt_t'(px.repeat_count);
            px.image_end = (image_left == '0);
            px.overrun   = clamped;
            owed.push_back(px);
            if (px.image_end)
                restart();
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                faults++;
            end
        endfunction

        // one accepted output beat
        function void check_pixel(pixel_t got);
            pixel_t want;

            if (owed.size() == 0) begin
                $error("pixel beat with nothing owed: r %0d g %0d b %0d a %0d rep %0d",
                       got.red, got.green, got.blue, got.alpha, got.repeat_count);
                faults++;
                return;
            end
            want = owed.pop_front();
            compare("red", want.red, got.red);
            compare("green", want.green, got.green);
            compare("blue", want.blue, got.blue);
            compare("alpha", want.alpha, got.alpha);
            compare("repeat_count", want.repeat_count, got.repeat_count);
            compare("image_end", {7'd0, want.image_end}, {7'd0, got.image_end});
            compare("overrun", {7'd0, want.overrun}, {7'd0, got.overrun});
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    byte_t                 s_data_byte;
    logic                  m_valid;
    logic                  m_ready;
    byte_t                 m_red;
    byte_t                 m_green;
    byte_t                 m_blue;
    byte_t                 m_alpha;
    byte_t                 m_repeat_count;
    logic                  m_image_end;
    logic                  m_overrun;
    logic                  cfg_wr_en;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rle_pixel_tracker tracker;
    bit steady;          // no idling on either side
    bit hold_request;    // ask the receiver for a long hold-off
    int bytes_accepted;
    int quiet_cycles;

    tga_rle_pixel_decoder i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_alpha        (m_alpha),
        .m_repeat_count (m_repeat_count),
        .m_image_end    (m_image_end),
        .m_overrun      (m_overrun),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    // The hold is counted here so the sender keeps pushing meanwhile and
    // the decoder has to drop s_ready.
    initial begin
        bit hold_taken;

        hold_taken = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_taken) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_taken = 1'b1;
            end
            m_ready = steady || ($urandom_range(99) >= 15);
        end
    end

    // Output monitor: every pixel beat goes to the tracker at the edge it is taken.
    always @(posedge aclk) begin
        pixel_t got;
        if (aresetn && m_valid && m_ready) begin
            got.red          = m_red;
            got.green        = m_green;
            got.blue         = m_blue;
            got.alpha        = m_alpha;
            got.repeat_count = m_repeat_count;
            got.image_end    = m_image_end;
            got.overrun      = m_overrun;
            tracker.check_pixel(got);
        end
    end

    // Watchdog: too long with no beat on either channel means a hang.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one byte; returns right after the edge that takes it.
    // Called after a rising edge; valid stays up between back-to-back beats.
    task automatic send_byte(input byte_t b);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 15) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_data_byte = b;
        do
            @(posedge aclk);
        while (!s_ready);
        tracker.note_byte(b);
        bytes_accepted++;
    endtask

    task automatic feed(input byte_t seq[$]);
        foreach (seq[k])
            send_byte(seq[k]);
    endtask

    // Register write, only with the decoder idle.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        tracker.write_reg(idx, value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Drop valid, wait for every owed pixel, then let the clock run on
    // in case the last bytes were header or partial-pixel bytes.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (tracker.owed.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One packet-shaped burst of random content, or a little noise.
    task automatic send_packet(input int bpp, inout int budget);
        int    pick;
        int    count;
        int    nbytes;
        bit    run;
        byte_t hdr;

        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise: a few arbitrary bytes, headers or pixel data alike
            nbytes = $urandom_range(1, 3);
            repeat (nbytes) send_byte(byte_t'($urandom_range(255)));
            budget -= nbytes;
            return;
        end
        run   = 1'($urandom_range(1));
        count = ($urandom_range(99) < 85) ? $urandom_range(7) : $urandom_range(127);
        // long raw packets stay rare, they eat the byte budget fast
        if (!run && count > 7 && $urandom_range(99) >= 30)
            count = $urandom_range(7);
        hdr    = {run, 7'(count)};
        nbytes = run ? bpp : (count + 1) * bpp;
        // broken packet: cut short
        if ($urandom_range(99) < 10)
            nbytes = $urandom_range(nbytes - 1);
        send_byte(hdr);
        repeat (nbytes) send_byte(byte_t'($urandom_range(255)));
        budget -= nbytes + 1;
    endtask

    initial begin
        int                    phase;
        int                    budget;
        int                    fmt_code;
        int                    bpp;
        int                    pick;
        logic [CFG_DATA_W-1:0] fmt_word;
        logic [CFG_DATA_W-1:0] total_word;

        tracker = new;
        tracker.power_up();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data_byte  = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_PIXEL_FORMAT;
        cfg_data     = '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        bytes_accepted = 0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ---- directed ----
        // gray, zero total taken as a one-pixel image; second packet overruns it
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_GRAY));
        write_reg(REG_PIXEL_TOTAL, '0);
        feed('{8'h00, 8'h00, 8'hff, 8'hff});
        settle();

        // BGRA run of two, extreme channel values
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_BGRA));
        write_reg(REG_PIXEL_TOTAL, 200);
        feed('{8'h81, 8'h00, 8'hff, 8'h55, 8'haa});
        settle();

        // format code three behaves as BGRA; image of TOTAL_MAX pixels; raw packet left
        // open so the register write must drop it
        write_reg(REG_PIXEL_FORMAT, 32'hffff_fffb);
        write_reg(REG_PIXEL_TOTAL, TOTAL_MAX);
        feed('{8'h7f, 8'h12, 8'h34, 8'h56, 8'h78});
        settle();

        // BGR, two-pixel image: raw 128 clamped to 2 with overrun, then the
        // next byte is a fresh header; finish on a partial pixel
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_BGR));
        write_reg(REG_PIXEL_TOTAL, 2);
        feed('{8'h7f, 8'h01, 8'h02, 8'h03, 8'hfe, 8'hfd, 8'hfc,
               8'h80, 8'h80, 8'h7f, 8'h01, 8'h00, 8'hab});
        settle();

        // ---- random phases ----
        bytes_accepted = 0;
        phase = 0;
        while (bytes_accepted < RANDOM_BYTES) begin
            fmt_code = $urandom_range(3);
            fmt_word = $urandom;
            if ($urandom_range(1))
                fmt_word[CFG_DATA_W-1:2] = '0;
            fmt_word[1:0] = fmt_t'(fmt_code);

            pick = $urandom_range(99);
            if (pick < 5)
                total_word = '0;
            else if (pick < 10)
                total_word = TOTAL_MAX;
            else if (pick < 15)
                total_word = $urandom;
            else
                total_word = $urandom_range(1, 150);

            // usually both registers, in either order; sometimes just one
            pick = $urandom_range(99);
            if (pick < 40) begin
                write_reg(REG_PIXEL_FORMAT, fmt_word);
                write_reg(REG_PIXEL_TOTAL, total_word);
            end else if (pick < 80) begin
                write_reg(REG_PIXEL_TOTAL, total_word);
                write_reg(REG_PIXEL_FORMAT, fmt_word);
            end else if (pick < 90) begin
                write_reg(REG_PIXEL_FORMAT, fmt_word);
            end else begin
                write_reg(REG_PIXEL_TOTAL, total_word);
            end

            bpp = (tracker.format == FMT_GRAY) ? 1 : (tracker.format == FMT_BGR) ? 3 : 4;

            steady = (phase == 2);
            if (phase == 4)
                hold_request = 1'b1;

            budget = $urandom_range(40, 90);
            while (budget > 0)
                send_packet(bpp, budget);
            settle();
            steady = 1'b0;
            phase++;
        end

        // drain and a short tail for any stray beat
        while (tracker.owed.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (tracker.faults == 0 && tracker.owed.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== tga_rle_pixel_decoder.f =====
+incdir+hdl
hdl/trd_pkg.sv
hdl/tga_rle_pixel_decoder.sv
sim/tb_top.sv
